// ===== hdl/weighted_running_covariance_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the weighted running covariance block.
// Used by the checker file that asserts on this block.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RUNNING_COVARIANCE_ASSERT_SVH
`define WEIGHTED_RUNNING_COVARIANCE_ASSERT_SVH

// Property that is checked at every edge, reset included.
`define WRC_ASSERT_AT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Property that is checked only outside reset.
`define WRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hdl/wrc_pkg.sv =====
// ----------------------------------------------------------------------------
// wrc_pkg
// Types and constants shared by the weighted running covariance modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrc_pkg;

   // Field widths.
   localparam int SAMPLE_W = 32;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 40;
   localparam int COV_W    = 64;

   // Magnitude of a deviation from a mean; the mean lies inside the sample range.
   localparam int MAG_W  = SAMPLE_W;
   // Weight times deviation magnitude, the dividend of a mean step.
   localparam int NUM_W  = WEIGHT_W + MAG_W;
   // Weight times both deviation magnitudes.
   localparam int PROD_W = NUM_W + MAG_W;
   // Fraction bits dropped from the Q.40 product to reach Q32.32.
   localparam int TERM_SHIFT = 8;

   // Serial steps per division and per multiplication.
   localparam int STEPS = MAG_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   // Stream beat widths.
   localparam int IN_BITS  = 2 * SAMPLE_W + WEIGHT_W;
   localparam int OUT_BITS = 2 * SAMPLE_W + COV_W + SUM_W;

   // Signed limits of the co-moment.
   localparam logic [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
   localparam logic [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_MEAN,
      ST_PROD,
      ST_TERM,
      ST_ACC,
      ST_OUT
   } wrc_state_type;

   // Control of a bit-serial unit.
   typedef struct packed {
      logic load;
      logic step;
   } wrc_ser_ctl_type;

endpackage

// ===== hdl/wrc_div.sv =====
// ----------------------------------------------------------------------------
// wrc_div
// Bit-serial restoring divider: one quotient bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrc_div (
   input  logic                       clock,
   input  wrc_pkg::wrc_ser_ctl_type   ctl,
   input  logic [wrc_pkg::NUM_W-1:0]  dividend,
   input  logic [wrc_pkg::SUM_W-1:0]  divisor,
   output logic [wrc_pkg::MAG_W-1:0]  quotient
);
   import wrc_pkg::*;

   // The quotient is known to fit MAG_W bits, so the upper dividend bits
   // start as the partial remainder and are already below the divisor.
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] sh_ff, sh_in;
   logic [SUM_W:0]   trial;
   logic             ge;

   // Shift the next dividend bit in, subtract when the divisor fits.
   always_comb begin
      trial  = {rem_ff, sh_ff[MAG_W-1]};
      ge     = (trial >= {1'b0, divisor});
      rem_in = rem_ff;
      sh_in  = sh_ff;
      if (ctl.load) begin
         rem_in = SUM_W'(dividend[NUM_W-1:MAG_W]);
         sh_in  = dividend[MAG_W-1:0];
      end else if (ctl.step) begin
         rem_in = ge ? SUM_W'(trial - {1'b0, divisor}) : trial[SUM_W-1:0];
         sh_in  = {sh_ff[MAG_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   // Dividend bits leave the top while quotient bits enter the bottom.
   assign quotient = sh_ff;

endmodule

// ===== hdl/wrc_smul.sv =====
// ----------------------------------------------------------------------------
// wrc_smul
// Bit-serial shift-add multiplier: one multiplier bit per step, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrc_smul (
   input  logic                        clock,
   input  wrc_pkg::wrc_ser_ctl_type    ctl,
   input  logic [wrc_pkg::NUM_W-1:0]   multiplicand,
   input  logic [wrc_pkg::MAG_W-1:0]   multiplier,
   output logic [wrc_pkg::PROD_W-1:0]  product
);
   import wrc_pkg::*;

   // Upper part accumulates, lower part holds the multiplier bits not yet used.
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [NUM_W:0]    sum;

   // Add the multiplicand when the current bit is set, then shift right.
   always_comb begin
      sum    = {1'b0, acc_ff[PROD_W-1:MAG_W]}
               + (acc_ff[0] ? {1'b0, multiplicand} : {(NUM_W+1){1'b0}});
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = {{NUM_W{1'b0}}, multiplier};
      end else if (ctl.step) begin
         acc_in = {sum, acc_ff[MAG_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign product = acc_ff;

endmodule

// ===== hdl/weighted_running_covariance.sv =====
// ----------------------------------------------------------------------------
// weighted_running_covariance
// Weighted running means and co-moment of a stream of (x, y, w) samples.
//
// The req stream carries one sample pair per beat; the rsp stream returns one
// beat per sample with both weighted means, the co-moment and the weight sum.
// Each accepted beat first adds its weight to the saturating sum, then two
// bit-serial dividers form both mean steps in parallel, and a bit-serial
// multiplier forms the co-moment term.
// A sample passes through ST_MUL, ST_DIV, ST_MEAN, ST_PROD, ST_TERM, ST_ACC
// and ST_OUT before the next is accepted; the result becomes valid as ST_OUT
// is left. A sample that leaves the weight sum at zero changes nothing else
// and goes from ST_MUL straight to ST_OUT; req_tready is high only while idle.
// The result waits in an output register; if the receiver stalls, the next
// sample is still accepted and computed, and it waits before its write-back
// into the output register until the previous beat is taken.
// Reset clears the weight sum, both means and the co-moment, and drops any
// pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_running_covariance (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // first_sample, second_sample, sample_weight (lowest bits first)
   input  logic [wrc_pkg::IN_BITS-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // first_average, second_average, co_moment, weight_total (lowest bits first)
   output logic [wrc_pkg::OUT_BITS-1:0]  rsp_tdata
);
   import wrc_pkg::*;

   // Control state.
   wrc_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Running state of the statistic.
   logic [SUM_W-1:0]           total_ff, total_in;
   logic signed [SAMPLE_W-1:0] mx_ff, mx_in;
   logic signed [SAMPLE_W-1:0] my_ff, my_in;
   logic [COV_W-1:0]           cov_ff, cov_in;

   // Per-sample work registers.
   logic [WEIGHT_W-1:0] w_ff;
   logic [MAG_W-1:0]    dxm_ff, dym_ff;
   logic                dxn_ff, dyn_ff;
   logic [NUM_W-1:0]    ny_ff;
   logic [COV_W-1:0]    term_ff, term_in;
   logic [OUT_BITS-1:0] rsp_data_ff;

   // Beat fields.
   logic [SAMPLE_W-1:0] in_x, in_y;
   logic [WEIGHT_W-1:0] in_w;
   logic                accept;

   // Datapath signals.
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_sat;
   logic [SAMPLE_W:0]   dx_fwd, dx_rev, dy_fwd, dy_rev;
   logic [MAG_W-1:0]    dxm, dym, amag;
   logic [NUM_W-1:0]    nx, ny;
   logic [MAG_W-1:0]    qx, qy;
   logic [PROD_W-1:0]   product;
   logic                big;
   logic [COV_W-1:0]    mlow, cov_sum;
   logic                cov_ovf, out_free;

   // Sequencer outputs.
   wrc_ser_ctl_type div_ctl, mul_ctl;
   logic            out_load;

   assign in_x   = req_tdata[SAMPLE_W-1:0];
   assign in_y   = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign in_w   = req_tdata[IN_BITS-1:2*SAMPLE_W];
   assign accept = req_tvalid && req_tready;

   // The output register is free when empty or when its beat leaves now.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_MUL;
         ST_MUL:  state_in = (total_ff == '0) ? ST_OUT : ST_DIV;
         ST_DIV:  if (cnt_ff == CNT_LAST) state_in = ST_MEAN;
         ST_MEAN: state_in = ST_PROD;
         ST_PROD: if (cnt_ff == CNT_LAST) state_in = ST_TERM;
         ST_TERM: state_in = ST_ACC;
         ST_ACC:  state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      div_ctl    = '0;
      mul_ctl    = '0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready   = 1'b1;
         ST_MUL:  div_ctl.load = 1'b1;
         ST_DIV:  div_ctl.step = 1'b1;
         ST_MEAN: mul_ctl.load = 1'b1;
         ST_PROD: mul_ctl.step = 1'b1;
         ST_OUT:  out_load     = out_free;
         default: req_tready   = 1'b0;
      endcase
   end

   // Weight sum with saturation, and deviation magnitudes from the old means.
   always_comb begin
      sum_wide = {1'b0, total_ff} + {{(SUM_W+1-WEIGHT_W){1'b0}}, in_w};
      sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      dx_fwd   = {in_x[SAMPLE_W-1], in_x} - {mx_ff[SAMPLE_W-1], mx_ff};
      dx_rev   = {mx_ff[SAMPLE_W-1], mx_ff} - {in_x[SAMPLE_W-1], in_x};
      dy_fwd   = {in_y[SAMPLE_W-1], in_y} - {my_ff[SAMPLE_W-1], my_ff};
      dy_rev   = {my_ff[SAMPLE_W-1], my_ff} - {in_y[SAMPLE_W-1], in_y};
      dxm      = dx_fwd[SAMPLE_W] ? dx_rev[MAG_W-1:0] : dx_fwd[MAG_W-1:0];
      dym      = dy_fwd[SAMPLE_W] ? dy_rev[MAG_W-1:0] : dy_fwd[MAG_W-1:0];
   end

   // Dividends of both mean steps.
   assign nx = NUM_W'(w_ff) * NUM_W'(dxm_ff);
   assign ny = NUM_W'(w_ff) * NUM_W'(dym_ff);

   // |x - new mean of x| equals |dx| less the step, with the sign of dx.
   assign amag = dxm_ff - qx;

   wrc_div u_div_x (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (nx),
      .divisor  (total_ff),
      .quotient (qx)
   );

   wrc_div u_div_y (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (ny),
      .divisor  (total_ff),
      .quotient (qy)
   );

   wrc_smul u_smul (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (ny_ff),
      .multiplier   (amag),
      .product      (product)
   );

   // Running state updates, term clamp and saturating co-moment sum.
   always_comb begin
      total_in = total_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      cov_in   = cov_ff;
      cnt_in   = (state_ff == ST_DIV || state_ff == ST_PROD) ? cnt_ff + 1'b1 : '0;

      big     = |product[PROD_W-1:COV_W+TERM_SHIFT-1];
      mlow    = {1'b0, product[COV_W+TERM_SHIFT-2:TERM_SHIFT]};
      term_in = (dxn_ff ^ dyn_ff) ? (big ? COV_MIN : COV_W'(0) - mlow)
                                  : (big ? COV_MAX : mlow);

      cov_sum = cov_ff + term_ff;
      cov_ovf = (cov_ff[COV_W-1] == term_ff[COV_W-1])
                && (cov_sum[COV_W-1] != cov_ff[COV_W-1]);

      if (accept) begin
         total_in = sum_sat;
      end
      if (state_ff == ST_MEAN) begin
         mx_in = dxn_ff ? mx_ff - $signed(qx) : mx_ff + $signed(qx);
         my_in = dyn_ff ? my_ff - $signed(qy) : my_ff + $signed(qy);
      end
      if (state_ff == ST_ACC) begin
         cov_in = cov_ovf ? (cov_ff[COV_W-1] ? COV_MIN : COV_MAX) : cov_sum;
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and statistic registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         mx_ff        <= '0;
         my_ff        <= '0;
         cov_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         mx_ff        <= mx_in;
         my_ff        <= my_in;
         cov_ff       <= cov_in;
      end
   end

   // Work registers, loaded in the state that produces them.
   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff   <= in_w;
         dxm_ff <= dxm;
         dym_ff <= dym;
         dxn_ff <= dx_fwd[SAMPLE_W];
         dyn_ff <= dy_fwd[SAMPLE_W];
      end
      if (state_ff == ST_MUL) begin
         ny_ff <= ny;
      end
      if (state_ff == ST_TERM) begin
         term_ff <= term_in;
      end
      if (out_load) begin
         rsp_data_ff <= {total_ff, cov_ff, my_ff, mx_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/wrc_checker.sv =====
// ----------------------------------------------------------------------------
// wrc_checker
// Port-level assertions for the weighted running covariance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_running_covariance_assert.svh"

module wrc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [wrc_pkg::IN_BITS-1:0]   req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [wrc_pkg::OUT_BITS-1:0]  rsp_tdata
);
   import wrc_pkg::*;

   logic req_beat;
   logic [IN_BITS-1:0] req_seen;

   assign req_beat = req_tvalid && req_tready;
   assign req_seen = req_tdata;

   // Reset leaves the block idle with no result pending.
   `WRC_ASSERT_AT(a_reset_idle, clock, reset |=> (!rsp_tvalid && req_tready), "not idle after reset")

   // A stalled result beat keeps its data.
   `WRC_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result changed while stalled")

   // A sample occupies the block: no second beat in the following cycle.
   `WRC_ASSERT(a_busy_after_beat, clock, reset, req_beat |=> !req_tready, "ready right after a beat")

   // A result appears only as the block goes back to idle.
   `WRC_ASSERT(a_rsp_at_idle, clock, reset, ($rose(rsp_tvalid) && $stable(req_seen)) || $rose(rsp_tvalid) |-> req_tready, "result raised while busy")

endmodule

bind weighted_running_covariance wrc_checker u_wrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
